>>> rtl/mesh_graph_laplacian_builder_top_defines.svh
// Assertion macros shared by the checker of the Laplacian builder.
// Depends on nothing; included by the checker file.
`ifndef MESH_GRAPH_LAPLACIAN_BUILDER_TOP_DEFINES_SVH
`define MESH_GRAPH_LAPLACIAN_BUILDER_TOP_DEFINES_SVH

// Clocked property, switched off while reset is held.
`define MGLB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property failed");

// Clocked property that is also checked while reset is held.
`define MGLB_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: property failed");

`endif

>>> rtl/mglb_pkg.sv
// Types and constants of the mesh Laplacian builder.
// Used by every module of the block; depends on nothing.
package mglb_pkg;

    localparam int MAX_VERTICES_DEF = 256;

    localparam int REQ_W    = 2;
    localparam int VTX_W    = 9;
    localparam int RC_W     = 8;
    localparam int ENTRY_W  = 10;
    localparam int VCOUNT_W = 9;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 9'd256;

    localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // Diagonal entries saturate here.
    localparam int DIAG_SAT = 511;
    localparam logic [ENTRY_W-1:0] ENTRY_NEG_ONE = {ENTRY_W{1'b1}};

    typedef enum logic [1:0] {
        OP_MARK,
        OP_READ,
        OP_CLR
    } op_kind_t;

    // One memory operation handed from the sequencer to the update stage.
    typedef struct packed {
        logic     valid;
        op_kind_t kind;
        logic     in_range;
    } op_ctrl_t;

endpackage

>>> rtl/mglb_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on mglb_pkg for its default sizes.
module mglb_ram #(
    parameter int DEPTH = mglb_pkg::MAX_VERTICES_DEF,
    parameter int WIDTH = mglb_pkg::MAX_VERTICES_DEF
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);
    import mglb_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // A read of the address being written returns the old contents.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/mglb_seq.sv
// Request sequencer: takes one request word and issues memory operations.
// Depends on mglb_pkg.
module mglb_seq #(
    parameter int MAX_VERTICES = mglb_pkg::MAX_VERTICES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mglb_pkg::REQ_W-1:0]        s_req_type,
    input  logic [mglb_pkg::VTX_W-1:0]        s_vertex_a,
    input  logic [mglb_pkg::VTX_W-1:0]        s_vertex_b,
    input  logic [mglb_pkg::VTX_W-1:0]        s_vertex_c,
    input  logic [mglb_pkg::RC_W-1:0]         s_row_index,
    input  logic [mglb_pkg::RC_W-1:0]         s_col_index,
    input  logic [mglb_pkg::VCOUNT_W-1:0]     vertex_count,
    input  logic                              out_free,
    output mglb_pkg::op_ctrl_t                op_ctrl,
    output logic [$clog2(MAX_VERTICES)-1:0]   op_row,
    output logic [$clog2(MAX_VERTICES)-1:0]   op_col
);
    import mglb_pkg::*;

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int NW = ($clog2(MAX_VERTICES + 1) > VTX_W) ? $clog2(MAX_VERTICES + 1) : VTX_W;
    localparam logic [1:0] ROT_LAST = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD,
        ST_READ
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   x_reg, x_next;
    logic [IDX_W-1:0]   y_reg, y_next;
    logic [IDX_W-1:0]   z_reg, z_next;
    logic               swap_reg, swap_next;
    logic [1:0]         rot_reg, rot_next;
    logic               in_range_reg, in_range_next;
    logic [NW-1:0]      n_eff;
    logic               face_ok;
    logic               rd_in_range;

    always_comb begin
        n_eff = (NW'(vertex_count) < NW'(MAX_VERTICES)) ? NW'(vertex_count)
                                                          : NW'(MAX_VERTICES);
        face_ok = (s_vertex_a != '0) && (s_vertex_b != '0) && (s_vertex_c != '0)
               && (NW'(s_vertex_a) <= n_eff) && (NW'(s_vertex_b) <= n_eff)
               && (NW'(s_vertex_c) <= n_eff);
        rd_in_range = (NW'(s_row_index) < n_eff) && (NW'(s_col_index) < n_eff);
    end

    // x, y and z hold the face's vertices during an add, x and y the row and
    // column during a read, and x the row being swept during a clear.
    always_comb begin
        state_next    = state_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        z_next        = z_reg;
        swap_next     = swap_reg;
        rot_next      = rot_reg;
        in_range_next = in_range_reg;
        op_ctrl       = '{valid: 1'b0, kind: OP_MARK, in_range: in_range_reg};
        op_row        = swap_reg ? y_reg : x_reg;
        op_col        = swap_reg ? x_reg : y_reg;
        case (state_reg)
            ST_CLEAR: begin
                op_ctrl.valid = 1'b1;
                op_ctrl.kind  = OP_CLR;
                op_row        = x_reg;
                op_col        = x_reg;
                if (x_reg == IDX_W'(MAX_VERTICES - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    x_next = x_reg + IDX_W'(1);
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_req_type)
                        REQ_ADD: begin
                            if (face_ok) begin
                                x_next     = IDX_W'(s_vertex_a - VTX_W'(1));
                                y_next     = IDX_W'(s_vertex_b - VTX_W'(1));
                                z_next     = IDX_W'(s_vertex_c - VTX_W'(1));
                                swap_next  = 1'b0;
                                rot_next   = '0;
                                state_next = ST_ADD;
                            end
                        end
                        REQ_READ: begin
                            x_next        = IDX_W'(s_row_index);
                            y_next        = IDX_W'(s_col_index);
                            in_range_next = rd_in_range;
                            swap_next     = 1'b0;
                            state_next    = ST_READ;
                        end
                        REQ_CLEAR: begin
                            x_next     = '0;
                            state_next = ST_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ADD: begin
                // Each pair is marked in both directions, then the face
                // rotates to its next edge.
                op_ctrl.valid = 1'b1;
                op_ctrl.kind  = OP_MARK;
                if (!swap_reg) begin
                    swap_next = 1'b1;
                end else begin
                    swap_next = 1'b0;
                    x_next    = y_reg;
                    y_next    = z_reg;
                    z_next    = x_reg;
                    if (rot_reg == ROT_LAST) begin
                        state_next = ST_IDLE;
                    end else begin
                        rot_next = rot_reg + 2'd1;
                    end
                end
            end
            ST_READ: begin
                op_ctrl.kind  = OP_READ;
                op_ctrl.valid = out_free;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            x_reg     <= '0;
            swap_reg  <= 1'b0;
            rot_reg   <= '0;
        end else begin
            state_reg <= state_next;
            x_reg     <= x_next;
            swap_reg  <= swap_next;
            rot_reg   <= rot_next;
        end
        y_reg        <= y_next;
        z_reg        <= z_next;
        in_range_reg <= in_range_next;
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

>>> rtl/mglb_rmw.sv
// Read-modify-write stage over the adjacency row memory and the count memory,
// with forwarding of the last write. Depends on mglb_pkg, mglb_ram.
module mglb_rmw #(
    parameter int MAX_VERTICES = mglb_pkg::MAX_VERTICES_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  mglb_pkg::op_ctrl_t                    op_ctrl,
    input  logic [$clog2(MAX_VERTICES)-1:0]       op_row,
    input  logic [$clog2(MAX_VERTICES)-1:0]       op_col,
    output logic                                  res_valid,
    output logic signed [mglb_pkg::ENTRY_W-1:0]   res_value
);
    import mglb_pkg::*;

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int CMP_W = (CNT_W > ENTRY_W) ? CNT_W : ENTRY_W;

    logic                    rd_en;
    logic [MAX_VERTICES-1:0] adj_rd_data;
    logic                    adj_wr_en;
    logic [IDX_W-1:0]        adj_wr_addr;
    logic [MAX_VERTICES-1:0] adj_wr_data;
    logic [CNT_W-1:0]        cnt_rd_data;
    logic                    cnt_wr_en;
    logic [IDX_W-1:0]        cnt_wr_addr;
    logic [CNT_W-1:0]        cnt_wr_data;

    op_ctrl_t                m_ctrl_reg;
    logic [IDX_W-1:0]        m_row_reg;
    logic [IDX_W-1:0]        m_col_reg;
    logic                    fwd_adj_valid_reg;
    logic [IDX_W-1:0]        fwd_adj_addr_reg;
    logic [MAX_VERTICES-1:0] fwd_adj_data_reg;
    logic                    fwd_cnt_valid_reg;
    logic [IDX_W-1:0]        fwd_cnt_addr_reg;
    logic [CNT_W-1:0]        fwd_cnt_data_reg;

    logic [MAX_VERTICES-1:0] row_cur;
    logic [CNT_W-1:0]        cnt_cur;
    logic [CMP_W-1:0]        cnt_wide;
    logic                    bit_old;

    assign rd_en = op_ctrl.valid && (op_ctrl.kind != OP_CLR);

    mglb_ram #(
        .DEPTH (MAX_VERTICES),
        .WIDTH (MAX_VERTICES)
    ) u_adj_ram (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (op_row),
        .rd_data (adj_rd_data),
        .wr_en   (adj_wr_en),
        .wr_addr (adj_wr_addr),
        .wr_data (adj_wr_data)
    );

    mglb_ram #(
        .DEPTH (MAX_VERTICES),
        .WIDTH (CNT_W)
    ) u_cnt_ram (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (op_col),
        .rd_data (cnt_rd_data),
        .wr_en   (cnt_wr_en),
        .wr_addr (cnt_wr_addr),
        .wr_data (cnt_wr_data)
    );

    // The memories return old data when the previous operation wrote the same
    // entry in the cycle of this read, so that write is taken from the
    // forwarding registers instead. Older writes are already in the memory.
    always_comb begin
        row_cur = (fwd_adj_valid_reg && (fwd_adj_addr_reg == m_row_reg))
                ? fwd_adj_data_reg : adj_rd_data;
        cnt_cur = (fwd_cnt_valid_reg && (fwd_cnt_addr_reg == m_col_reg))
                ? fwd_cnt_data_reg : cnt_rd_data;
        cnt_wide = CMP_W'(cnt_cur);
        bit_old  = row_cur[m_col_reg];

        adj_wr_en   = 1'b0;
        adj_wr_addr = m_row_reg;
        adj_wr_data = row_cur | (MAX_VERTICES'(1) << m_col_reg);
        cnt_wr_en   = 1'b0;
        cnt_wr_addr = m_col_reg;
        cnt_wr_data = cnt_cur + CNT_W'(1);
        res_valid   = 1'b0;
        res_value   = '0;

        if (m_ctrl_reg.valid) begin
            case (m_ctrl_reg.kind)
                OP_MARK: begin
                    // Only a newly set bit adds to its column's count.
                    adj_wr_en = !bit_old;
                    cnt_wr_en = !bit_old;
                end
                OP_CLR: begin
                    adj_wr_en   = 1'b1;
                    adj_wr_data = '0;
                    cnt_wr_en   = 1'b1;
                    cnt_wr_addr = m_row_reg;
                    cnt_wr_data = '0;
                end
                OP_READ: begin
                    res_valid = 1'b1;
                    if (m_ctrl_reg.in_range) begin
                        if (m_row_reg == m_col_reg) begin
                            if (cnt_wide > CMP_W'(DIAG_SAT)) begin
                                res_value = ENTRY_W'(DIAG_SAT);
                            end else begin
                                res_value = ENTRY_W'(cnt_wide);
                            end
                        end else if (bit_old) begin
                            res_value = ENTRY_NEG_ONE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_ctrl_reg        <= '0;
            fwd_adj_valid_reg <= 1'b0;
            fwd_cnt_valid_reg <= 1'b0;
        end else begin
            m_ctrl_reg        <= op_ctrl;
            fwd_adj_valid_reg <= adj_wr_en;
            fwd_cnt_valid_reg <= cnt_wr_en;
        end
        m_row_reg        <= op_row;
        m_col_reg        <= op_col;
        fwd_adj_addr_reg <= adj_wr_addr;
        fwd_adj_data_reg <= adj_wr_data;
        fwd_cnt_addr_reg <= cnt_wr_addr;
        fwd_cnt_data_reg <= cnt_wr_data;
    end

endmodule

>>> rtl/mesh_graph_laplacian_builder_top.sv
// Top level of the mesh graph Laplacian builder: configuration register,
// sequencer, update stage and output register. Depends on mglb_pkg, mglb_seq, mglb_rmw.
//
//   Channel   Direction  Handshake              Word
//   cfg       in         cfg_valid / cfg_ready  cfg_vertex_count
//   s         in         s_valid / s_ready      request, three vertices, row, column
//   m         out        m_valid / m_ready      Laplacian entry
//
// An add makes six bit updates, which share the single read and write port of
// the row memory, one per cycle; no new word is taken until they are issued.
// A read passes through the sequencer's read state, the update stage and the
// output register; it waits while a previous entry is still held in the output
// register. An add with a bad face, and the unused request code, are dropped.
// A clear, and the pass that follows reset, sweeps all MAX_VERTICES rows (256 by
// default) one row a cycle, with s_ready low. cfg_ready is always high.
module mesh_graph_laplacian_builder_top #(
    parameter int MAX_VERTICES = mglb_pkg::MAX_VERTICES_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mglb_pkg::VCOUNT_W-1:0]        cfg_vertex_count,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [mglb_pkg::REQ_W-1:0]           s_req_type,
    input  logic [mglb_pkg::VTX_W-1:0]           s_vertex_a,
    input  logic [mglb_pkg::VTX_W-1:0]           s_vertex_b,
    input  logic [mglb_pkg::VTX_W-1:0]           s_vertex_c,
    input  logic [mglb_pkg::RC_W-1:0]            s_row_index,
    input  logic [mglb_pkg::RC_W-1:0]            s_col_index,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [mglb_pkg::ENTRY_W-1:0]  m_entry_value
);
    import mglb_pkg::*;

    localparam int IDX_W = $clog2(MAX_VERTICES);

    logic [VCOUNT_W-1:0]       vcount_reg;
    logic                      m_valid_reg;
    logic signed [ENTRY_W-1:0] m_entry_value_reg;
    logic                      out_free;
    op_ctrl_t                  op_ctrl;
    logic [IDX_W-1:0]          op_row;
    logic [IDX_W-1:0]          op_col;
    logic                      res_valid;
    logic signed [ENTRY_W-1:0] res_value;

    assign cfg_ready = 1'b1;

    // A read is only issued when the output register will be free as its
    // entry arrives.
    assign out_free = !m_valid_reg || m_ready;

    mglb_seq #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_vertex_a   (s_vertex_a),
        .s_vertex_b   (s_vertex_b),
        .s_vertex_c   (s_vertex_c),
        .s_row_index  (s_row_index),
        .s_col_index  (s_col_index),
        .vertex_count (vcount_reg),
        .out_free     (out_free),
        .op_ctrl      (op_ctrl),
        .op_row       (op_row),
        .op_col       (op_col)
    );

    mglb_rmw #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_rmw (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op_ctrl   (op_ctrl),
        .op_row    (op_row),
        .op_col    (op_col),
        .res_valid (res_valid),
        .res_value (res_value)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg  <= VCOUNT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                vcount_reg <= cfg_vertex_count;
            end
            if (res_valid) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (res_valid) begin
            m_entry_value_reg <= res_value;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_entry_value = m_entry_value_reg;

endmodule

>>> rtl/mglb_checker.sv
// Port-level checks of the mesh Laplacian builder, bound to its top level.
// Depends on mglb_pkg and the assertion macro header.
`include "mesh_graph_laplacian_builder_top_defines.svh"

module mglb_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic [mglb_pkg::REQ_W-1:0]           s_req_type,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic signed [mglb_pkg::ENTRY_W-1:0]  m_entry_value
);
    import mglb_pkg::*;

    // Reset starts the clearing pass, so no word is taken just after it.
    `MGLB_ASSERT_NR(a_reset_clears, aclk, !aresetn |=> !s_ready)

    // A clear sweeps the memories before the next word.
    `MGLB_ASSERT(a_clear_busy, aclk, aresetn, s_valid && s_ready && s_req_type == REQ_CLEAR |=> !s_ready)

    // A read moves the sequencer into its read state, so s_ready drops after acceptance.
    `MGLB_ASSERT(a_read_busy, aclk, aresetn, s_valid && s_ready && s_req_type == REQ_READ |=> !s_ready)

    // An entry is held until it is taken.
    `MGLB_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_entry_value))

    // The only negative entry is minus one.
    `MGLB_ASSERT(a_out_range, aclk, aresetn, m_valid && m_entry_value[ENTRY_W-1] |-> (&m_entry_value))

endmodule

bind mesh_graph_laplacian_builder_top mglb_checker u_mglb_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_req_type    (s_req_type),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_entry_value (m_entry_value)
);
